### rtl/urrb_pkg.sv
// ----------------------------------------------------------------------------
// urrb_pkg
// Types and codes shared by the serial receive ring buffer modules.
// ----------------------------------------------------------------------------
package urrb_pkg;

    localparam int CMD_W     = 3;
    localparam int BYTE_W    = 8;
    localparam int COUNT_W   = 6;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 1;

    localparam logic [CMD_W-1:0] CMD_RX   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK = 3'd2;
    localparam logic [CMD_W-1:0] CMD_OVF  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TX   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_LISTENING = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT    = 1'd1;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] byte_in;
    } t_in;

    typedef struct packed {
        logic [BYTE_W-1:0]  data_out;
        logic               data_valid;
        logic [COUNT_W-1:0] stored_count;
        logic               overflow_seen;
        logic [BYTE_W-1:0]  tx_byte;
        logic               tx_valid;
    } t_out;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic read;
        logic exec;
    } t_dp_cmd;

endpackage

### rtl/urrb_ctrl.sv
// ----------------------------------------------------------------------------
// urrb_ctrl
// Sequencer: capture, memory read, commit and result strobe.
// ----------------------------------------------------------------------------
module urrb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    output logic              o_result_valid,
    output urrb_pkg::t_dp_cmd o_dp_cmd
);
    import urrb_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EXEC
    } t_state;

    t_state r_state, n_state;
    logic   r_done;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_READ;
            end
            S_READ:  n_state = S_EXEC;
            S_EXEC:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_EXEC);
        end
    end

    assign o_busy           = (r_state != S_IDLE);
    assign o_result_valid   = r_done;
    assign o_dp_cmd.capture = i_start && (r_state == S_IDLE);
    assign o_dp_cmd.read    = (r_state == S_READ);
    assign o_dp_cmd.exec    = (r_state == S_EXEC);

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |=> o_busy)
        else $error("accepted transaction did not raise busy");
    a_strobe_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state == S_EXEC))
        else $error("result strobe without commit");
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("result strobe held for two cycles");
    a_exec_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dp_cmd.read |=> o_dp_cmd.exec)
        else $error("memory read not followed by commit");
`endif

endmodule

### rtl/urrb_datapath.sv
// ----------------------------------------------------------------------------
// urrb_datapath
// Byte store, pointers, overflow flag, configuration and result register.
// ----------------------------------------------------------------------------
module urrb_datapath #(
    parameter int BUF_DEPTH = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  urrb_pkg::t_dp_cmd                  i_dp_cmd,
    input  urrb_pkg::t_in                      i_item,
    input  logic                               i_cfg_valid,
    input  logic [urrb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [urrb_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    output urrb_pkg::t_out                     o_result
);
    import urrb_pkg::*;

    localparam int PTR_W = (BUF_DEPTH > 2) ? $clog2(BUF_DEPTH) : 1;
    localparam int CW    = (PTR_W + 1 > COUNT_W) ? PTR_W + 1 : COUNT_W;
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(BUF_DEPTH - 1);
    localparam logic [CW-1:0]    DEPTH_CW = CW'(BUF_DEPTH);

    logic [BYTE_W-1:0] r_mem [BUF_DEPTH];
    logic [BYTE_W-1:0] r_rd_data;
    t_in               r_item;
    t_out              r_out, n_out;
    logic [PTR_W-1:0]  r_rp, n_rp, r_wp, n_wp, wp_next;
    logic              r_ovf, n_ovf;
    logic              r_listening, r_invert;
    logic              mem_we;
    logic [BYTE_W-1:0] byte_v;
    logic [CW-1:0]     rp_x, wp_x, cnt;

    assign byte_v  = r_item.byte_in ^ {BYTE_W{r_invert}};
    assign wp_next = (r_wp == LAST_PTR) ? '0 : r_wp + 1'b1;

    always_comb begin
        n_rp   = r_rp;
        n_wp   = r_wp;
        n_ovf  = r_ovf;
        mem_we = 1'b0;
        n_out  = '0;
        case (r_item.cmd)
            CMD_RX: begin
                if (r_listening) begin
                    if (wp_next != r_rp) begin
                        mem_we = 1'b1;
                        n_wp   = wp_next;
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
            end
            CMD_POP, CMD_PEEK: begin
                if (r_listening && (r_rp != r_wp)) begin
                    n_out.data_out   = r_rd_data;
                    n_out.data_valid = 1'b1;
                    if (r_item.cmd == CMD_POP) begin
                        n_rp = (r_rp == LAST_PTR) ? '0 : r_rp + 1'b1;
                    end
                end
            end
            CMD_OVF: begin
                n_out.overflow_seen = r_ovf;
                n_ovf               = 1'b0;
            end
            CMD_TX: begin
                n_out.tx_byte  = byte_v;
                n_out.tx_valid = 1'b1;
            end
            default: ;
        endcase
        // count after this step, wrapped to the field width
        rp_x = CW'(n_rp);
        wp_x = CW'(n_wp);
        cnt  = (wp_x >= rp_x) ? (wp_x - rp_x) : (wp_x + DEPTH_CW - rp_x);
        n_out.stored_count = r_listening ? cnt[COUNT_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.capture) r_item <= i_item;
        if (i_dp_cmd.read) r_rd_data <= r_mem[r_rp];
        if (i_dp_cmd.exec && mem_we) r_mem[r_wp] <= byte_v;
        if (i_dp_cmd.exec) r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp        <= '0;
            r_wp        <= '0;
            r_ovf       <= 1'b0;
            r_listening <= 1'b0;
            r_invert    <= 1'b0;
        end else begin
            if (i_dp_cmd.exec) begin
                r_rp  <= n_rp;
                r_wp  <= n_wp;
                r_ovf <= n_ovf;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_LISTENING: r_listening <= i_cfg_data[0];
                    CFG_INVERT:    r_invert    <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    assign o_result = r_out;

`ifndef SYNTHESIS
    a_rp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rp <= LAST_PTR)
        else $error("read pointer past end of store");
    a_wp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wp <= LAST_PTR)
        else $error("write pointer past end of store");
    a_ptr_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_dp_cmd.exec |=> $stable(r_rp) && $stable(r_wp))
        else $error("pointer moved outside commit");
`endif

endmodule

### rtl/uart_receive_ring_buffer_unit.sv
// ----------------------------------------------------------------------------
// uart_receive_ring_buffer_unit
// Serial receive ring buffer, one slot kept empty, with transmit pass-through.
// ----------------------------------------------------------------------------
// sequence: capture at the accepting edge, store read, commit and result strobe
// no new transaction is accepted until the commit; o_busy is high meanwhile
// the registered read port of the byte store sets the store read step
// results are strobed for one cycle and cannot be stalled
// synchronous reset clears pointers, overflow flag and configuration
module uart_receive_ring_buffer_unit #(
    parameter int BUF_DEPTH = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  urrb_pkg::t_in                  i_item,
    output logic                           o_result_valid,
    output urrb_pkg::t_out                 o_result,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [urrb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [urrb_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import urrb_pkg::*;

    t_dp_cmd dp_cmd;

    assign o_cfg_ready = 1'b1;

    urrb_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .o_result_valid (o_result_valid),
        .o_dp_cmd       (dp_cmd)
    );

    urrb_datapath #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dp_cmd    (dp_cmd),
        .i_item      (i_item),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_result    (o_result)
    );

endmodule
